@@ sv/rv32ex_pkg.sv @@
// rv32ex_pkg: word types, opcode codes and stop causes for the RV32I execute unit.
// Depends on nothing; used by rv32i_execute_unit and rv32i_execute_unit_tb.
`default_nettype none

package rv32ex_pkg;

  localparam int unsigned MEM_WORDS_DEFAULT = 4096;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [4:0]  REG_ECALL_ARG = 5'd17;
  localparam logic [31:0] EXIT_CODE     = 32'd94;

  typedef enum logic [1:0] {
    CAUSE_RUN     = 2'd0,
    CAUSE_EXIT    = 2'd1,
    CAUSE_ECALL   = 2'd2,
    CAUSE_ILLEGAL = 2'd3
  } cause_t;

  typedef struct packed {
    logic [6:0]         opcode;
    logic [2:0]         funct3;
    logic [6:0]         funct7;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic [31:0]        pc_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic [1:0]  stop_cause;
  } out_word_t;

endpackage

`default_nettype wire

@@ sv/rv32i_execute_unit.sv @@
// rv32i_execute_unit: RV32I execute stage with register file and byte-lane data memory.
// Depends on rv32ex_pkg.
//
//   channel | valid        | stall        | word
//   input   | instr_valid  | instr_stall  | instr  (rv32ex_pkg::in_word_t)
//   output  | result_valid | result_stall | result (rv32ex_pkg::out_word_t)
//
// Three stages: register file read, execute with data memory access, load
// alignment and write back into the output register. An independent word is
// taken every cycle; a word that reads the register written by the word just
// ahead of it is held while that word is in execute, as loaded data leave
// the synchronous data memory only in the align stage. Reset clears the
// register file valid bits, the pipeline and the output register; no clearing
// pass. All stages hold while result_stall keeps a full output register.
`default_nettype none

module rv32i_execute_unit #(
  parameter int unsigned MEM_WORDS = rv32ex_pkg::MEM_WORDS_DEFAULT
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  instr_valid,
  output logic                 instr_stall,
  input  rv32ex_pkg::in_word_t instr,
  output logic                 result_valid,
  input  wire                  result_stall,
  output rv32ex_pkg::out_word_t result
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef struct packed {
    logic [31:0]        next_pc;
    logic [4:0]         widx;
    logic [31:0]        value;
    rv32ex_pkg::cause_t cause;
    logic               is_load;
    logic [2:0]         funct3;
    logic [1:0]         offset;
  } ex_word_t;

  logic advance;
  logic accept;
  logic [4:0] addr_a_in;

  // register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid;
  logic [31:0] ra_data, rb_data;
  logic        ra_ok, rb_ok;
  logic        wb_valid;
  logic [4:0]  wb_index;
  logic [31:0] wb_value;

  // execute stage
  logic                 s1_valid;
  rv32ex_pkg::in_word_t s1;
  logic [4:0]           s1_addr_a;
  logic [31:0]          op_a, op_b, imm, addr, opb, alu_res;
  logic                 alu_alt;
  logic [4:0]           sh;
  ex_word_t             ex;
  logic                 wr, is_store, taken;
  logic [AW-1:0]        wbase, wnext;
  logic [1:0]           lane_k [4];
  logic [AW-1:0]        lane_idx [4];
  logic [7:0]           lane_wdata [4];
  logic [3:0]           lane_we;
  logic [7:0]           lane_rdata [4];
  logic [1:0]           size_mask;

  // align stage
  logic        s2_valid;
  ex_word_t    s2;
  logic [31:0] ld_word, ld_value, final_value;

  assign advance   = !result_valid || !result_stall;
  assign addr_a_in = (instr.opcode == rv32ex_pkg::OP_SYSTEM) ? rv32ex_pkg::REG_ECALL_ARG
                                                             : instr.src_reg_a;
  assign instr_stall = !advance ||
                       (s1_valid && ex.widx != 5'd0 &&
                        (ex.widx == addr_a_in || ex.widx == instr.src_reg_b));
  assign accept = instr_valid && !instr_stall;

  // register file read and write
  always_ff @(posedge clk) begin
    if (accept) begin
      ra_data <= rf_mem[addr_a_in];
      rb_data <= rf_mem[instr.src_reg_b];
      ra_ok   <= rf_valid[addr_a_in];
      rb_ok   <= rf_valid[instr.src_reg_b];
    end
    if (advance && s2_valid && s2.widx != 5'd0) begin
      rf_mem[s2.widx] <= final_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      wb_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      if (s2_valid && s2.widx != 5'd0) begin
        rf_valid[s2.widx] <= 1'b1;
      end
      wb_valid     <= s2_valid && s2.widx != 5'd0;
      s1_valid     <= accept;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1        <= instr;
      s1_addr_a <= addr_a_in;
    end
    if (advance) begin
      wb_index <= s2.widx;
      wb_value <= final_value;
      s2       <= ex;
      result.next_pc     <= s2.next_pc;
      result.write_index <= s2.widx;
      result.write_value <= final_value;
      result.stop_cause  <= s2.cause;
    end
  end

  // operands, forwarded from the write made at the read edge
  always_comb begin
    if (wb_valid && wb_index == s1_addr_a) begin
      op_a = wb_value;
    end else begin
      op_a = ra_ok ? ra_data : 32'd0;
    end
    if (wb_valid && wb_index == s1.src_reg_b) begin
      op_b = wb_value;
    end else begin
      op_b = rb_ok ? rb_data : 32'd0;
    end
  end

  assign imm  = s1.immediate;
  assign addr = op_a + imm;

  // ALU
  always_comb begin
    opb = (s1.opcode == rv32ex_pkg::OP_REG) ? op_b : imm;
    sh  = opb[4:0];
    if (s1.opcode == rv32ex_pkg::OP_REG) begin
      alu_alt = (s1.funct3 == rv32ex_pkg::F3_ADD || s1.funct3 == rv32ex_pkg::F3_SR) &&
                s1.funct7 != 7'd0;
    end else begin
      alu_alt = s1.funct3 == rv32ex_pkg::F3_SR && imm[31:5] != 27'd0;
    end
    unique case (s1.funct3)
      rv32ex_pkg::F3_ADD:  alu_res = alu_alt ? op_a - opb : op_a + opb;
      rv32ex_pkg::F3_SLL:  alu_res = op_a << sh;
      rv32ex_pkg::F3_SLT:  alu_res = {31'd0, $signed(op_a) < $signed(opb)};
      rv32ex_pkg::F3_SLTU: alu_res = {31'd0, op_a < opb};
      rv32ex_pkg::F3_XOR:  alu_res = op_a ^ opb;
      rv32ex_pkg::F3_SR:   alu_res = alu_alt ? 32'($signed(op_a) >>> sh) : op_a >> sh;
      rv32ex_pkg::F3_OR:   alu_res = op_a | opb;
      rv32ex_pkg::F3_AND:  alu_res = op_a & opb;
      default:             alu_res = op_a & opb;
    endcase
  end

  // decode and next pc
  always_comb begin
    ex.next_pc = s1.pc_in;
    ex.value   = 32'd0;
    ex.cause   = rv32ex_pkg::CAUSE_RUN;
    ex.is_load = 1'b0;
    ex.funct3  = s1.funct3;
    ex.offset  = addr[1:0];
    ex.widx    = 5'd0;
    wr         = 1'b0;
    is_store   = 1'b0;
    taken      = 1'b0;
    unique case (s1.opcode)
      rv32ex_pkg::OP_LUI: begin
        ex.value = imm;
        wr = 1'b1;
      end
      rv32ex_pkg::OP_AUIPC: begin
        ex.value = s1.pc_in - 32'd4 + imm;
        wr = 1'b1;
      end
      rv32ex_pkg::OP_JAL: begin
        ex.value   = s1.pc_in;
        ex.next_pc = s1.pc_in + imm - 32'd4;
        wr = 1'b1;
      end
      rv32ex_pkg::OP_JALR: begin
        if (s1.funct3 != 3'd0) begin
          ex.cause = rv32ex_pkg::CAUSE_ILLEGAL;
        end else begin
          ex.value   = s1.pc_in;
          ex.next_pc = {addr[31:1], 1'b0};
          wr = 1'b1;
        end
      end
      rv32ex_pkg::OP_BRANCH: begin
        unique case (s1.funct3)
          rv32ex_pkg::F3_BEQ:  taken = op_a == op_b;
          rv32ex_pkg::F3_BNE:  taken = op_a != op_b;
          rv32ex_pkg::F3_BLT:  taken = $signed(op_a) < $signed(op_b);
          rv32ex_pkg::F3_BGE:  taken = $signed(op_a) >= $signed(op_b);
          rv32ex_pkg::F3_BLTU: taken = op_a < op_b;
          rv32ex_pkg::F3_BGEU: taken = op_a >= op_b;
          default:             ex.cause = rv32ex_pkg::CAUSE_ILLEGAL;
        endcase
        if (taken) begin
          ex.next_pc = s1.pc_in + imm - 32'd4;
        end
      end
      rv32ex_pkg::OP_LOAD: begin
        if (s1.funct3 inside {rv32ex_pkg::F3_LB, rv32ex_pkg::F3_LH, rv32ex_pkg::F3_LW,
                              rv32ex_pkg::F3_LBU, rv32ex_pkg::F3_LHU}) begin
          ex.is_load = 1'b1;
          wr = 1'b1;
        end else begin
          ex.cause = rv32ex_pkg::CAUSE_ILLEGAL;
        end
      end
      rv32ex_pkg::OP_STORE: begin
        if (s1.funct3 <= 3'd2) begin
          is_store = 1'b1;
        end else begin
          ex.cause = rv32ex_pkg::CAUSE_ILLEGAL;
        end
      end
      rv32ex_pkg::OP_IMM, rv32ex_pkg::OP_REG: begin
        ex.value = alu_res;
        wr = 1'b1;
      end
      rv32ex_pkg::OP_SYSTEM: begin
        if (s1.funct3 != 3'd0) begin
          ex.cause = rv32ex_pkg::CAUSE_ILLEGAL;
        end else if (op_a == rv32ex_pkg::EXIT_CODE) begin
          ex.cause = rv32ex_pkg::CAUSE_EXIT;
        end else begin
          ex.cause = rv32ex_pkg::CAUSE_ECALL;
        end
      end
      default: ex.cause = rv32ex_pkg::CAUSE_ILLEGAL;
    endcase
    if (ex.cause != rv32ex_pkg::CAUSE_RUN) begin
      ex.next_pc = 32'd0;
      wr = 1'b0;
    end
    if (wr && s1.dest_reg != 5'd0) begin
      ex.widx = s1.dest_reg;
    end else begin
      ex.value   = 32'd0;
      ex.is_load = 1'b0;
    end
  end

  // byte lanes: lane L holds byte k = L - offset of the access
  assign wbase     = addr[AW+1:2];
  assign wnext     = wbase + AW'(1);
  assign size_mask = {s1.funct3[1], s1.funct3[1] | s1.funct3[0]};

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lane_k[l]     = 2'(l) - addr[1:0];
      lane_idx[l]   = (2'(l) < addr[1:0]) ? wnext : wbase;
      lane_wdata[l] = op_b[{lane_k[l], 3'b000} +: 8];
      lane_we[l]    = is_store && lane_k[l] <= size_mask;
    end
  end

  for (genvar gl = 0; gl < 4; gl++) begin : g_lane
    logic [7:0] bank [MEM_WORDS];
    always_ff @(posedge clk) begin
      if (advance && s1_valid) begin
        if (lane_we[gl]) begin
          bank[lane_idx[gl]] <= lane_wdata[gl];
        end
        lane_rdata[gl] <= bank[lane_idx[gl]];
      end
    end
  end

  // load alignment and extension
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_word[8*k +: 8] = lane_rdata[2'(k) + s2.offset];
    end
    unique case (s2.funct3)
      rv32ex_pkg::F3_LB:  ld_value = {{24{ld_word[7]}}, ld_word[7:0]};
      rv32ex_pkg::F3_LH:  ld_value = {{16{ld_word[15]}}, ld_word[15:0]};
      rv32ex_pkg::F3_LBU: ld_value = {24'd0, ld_word[7:0]};
      rv32ex_pkg::F3_LHU: ld_value = {16'd0, ld_word[15:0]};
      default:            ld_value = ld_word;
    endcase
    final_value = s2.is_load ? ld_value : s2.value;
  end

endmodule

`default_nettype wire

@@ tb/sv/rv32i_execute_unit_tb.sv @@
// rv32i_execute_unit_tb: self-checking bench for the RV32I execute unit, with a predictor of
// the register file and byte-lane data memory, randomized idling and a drained pause.
// Depends on rv32ex_pkg and rv32i_execute_unit.
`default_nettype none

module rv32i_execute_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rv32ex_pkg::*;

  localparam int unsigned MEM_WORDS    = MEM_WORDS_DEFAULT;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 30;

  localparam logic [2:0] F3_JALR   = 3'd0;
  localparam logic [2:0] F3_ECALL  = 3'd0;
  localparam logic [2:0] F3_SB     = 3'd0;
  localparam logic [2:0] F3_SH     = 3'd1;
  localparam logic [2:0] F3_SW     = 3'd2;
  localparam logic [2:0] F3_BR_BAD = 3'd2;
  localparam logic [2:0] F3_LD_BAD = 3'd3;
  localparam logic [6:0] OP_UNKNOWN = 7'h7f;
  localparam logic [6:0] F7_ALT     = 7'h20;

  typedef struct packed {
    in_word_t   instr;
    out_word_t  outcome;
    logic       drain;
    logic [4:0] gap;
  } program_item_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      instr_valid = 1'b0;
  logic      instr_stall;
  in_word_t  instr = '0;
  logic      result_valid;
  logic      result_stall = 1'b1;
  out_word_t result;

  logic [31:0]   regs [32];
  logic [31:0]   mem_words [MEM_WORDS];
  bit            byte_written [MEM_WORDS*4];
  logic [31:0]   last_store_addr;
  program_item_t program_q [$];
  out_word_t     retire_q [$];

  program_item_t drv_item;
  bit            drv_busy;
  bit            gap_armed;
  int            gap_left;
  int            stall_left;
  out_word_t     want;

  int n_queued, n_loads, n_stores, n_halts, n_checked, n_errors, cycles;

  rv32i_execute_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_stall  (instr_stall),
    .instr        (instr),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] reg_value(logic [4:0] idx);
    return (idx == 5'd0) ? 32'd0 : regs[idx];
  endfunction

  function automatic int unsigned byte_slot(logic [31:0] addr);
    return ((addr >> 2) % MEM_WORDS) * 4 + addr[1:0];
  endfunction

  function automatic logic [31:0] mem_read(logic [31:0] addr, int n);
    logic [31:0] v;
    int unsigned s;
    v = '0;
    for (int k = 0; k < n; k++) begin
      s = byte_slot(addr + k);
      v |= ((mem_words[s >> 2] >> (8 * (s & 3))) & 32'hff) << (8 * k);
    end
    return v;
  endfunction

  function automatic void mem_write(logic [31:0] addr, logic [31:0] v, int n);
    int unsigned s;
    for (int k = 0; k < n; k++) begin
      s = byte_slot(addr + k);
      mem_words[s >> 2] = (mem_words[s >> 2] & ~(32'hff << (8 * (s & 3))))
                        | (((v >> (8 * k)) & 32'hff) << (8 * (s & 3)));
      byte_written[s] = 1'b1;
    end
  endfunction

  function automatic bit bytes_written(logic [31:0] addr, int n);
    for (int k = 0; k < n; k++) begin
      if (!byte_written[byte_slot(addr + k)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] alu_calc(logic [2:0] f3, bit alt, logic [31:0] a,
                                           logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      F3_ADD: begin
        if (alt) return a - b;
        return a + b;
      end
      F3_SLL:  return a << sh;
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR: begin
        if (alt) return $signed(a) >>> sh;
        return a >> sh;
      end
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic out_word_t execute_instr(in_word_t w);
    logic [31:0] a, b, imm, pc, addr, nxt, val;
    logic [4:0]  rd;
    bit          wr, taken;
    cause_t      cause;
    out_word_t   r;
    a     = reg_value(w.src_reg_a);
    b     = reg_value(w.src_reg_b);
    imm   = w.immediate;
    pc    = w.pc_in;
    addr  = a + imm;
    nxt   = pc;
    val   = '0;
    rd    = w.dest_reg;
    wr    = 1'b0;
    taken = 1'b0;
    cause = CAUSE_RUN;
    case (w.opcode)
      OP_LUI: begin
        val = imm;
        wr  = 1'b1;
      end
      OP_AUIPC: begin
        val = pc - 4 + imm;
        wr  = 1'b1;
      end
      OP_JAL: begin
        val = pc;
        wr  = 1'b1;
        nxt = pc + imm - 4;
      end
      OP_JALR: begin
        if (w.funct3 != F3_JALR) begin
          cause = CAUSE_ILLEGAL;
        end else begin
          val = pc;
          wr  = 1'b1;
          nxt = addr & ~32'd1;
        end
      end
      OP_BRANCH: begin
        case (w.funct3)
          F3_BEQ:  taken = a == b;
          F3_BNE:  taken = a != b;
          F3_BLT:  taken = $signed(a) < $signed(b);
          F3_BGE:  taken = $signed(a) >= $signed(b);
          F3_BLTU: taken = a < b;
          F3_BGEU: taken = a >= b;
          default: cause = CAUSE_ILLEGAL;
        endcase
        if (taken) nxt = pc + imm - 4;
      end
      OP_LOAD: begin
        wr = 1'b1;
        case (w.funct3)
          F3_LB: begin
            val = mem_read(addr, 1);
            val = {{24{val[7]}}, val[7:0]};
          end
          F3_LH: begin
            val = mem_read(addr, 2);
            val = {{16{val[15]}}, val[15:0]};
          end
          F3_LW:   val = mem_read(addr, 4);
          F3_LBU:  val = mem_read(addr, 1);
          F3_LHU:  val = mem_read(addr, 2);
          default: cause = CAUSE_ILLEGAL;
        endcase
      end
      OP_STORE: begin
        if (w.funct3 <= F3_SW) mem_write(addr, b, 1 << w.funct3);
        else cause = CAUSE_ILLEGAL;
      end
      OP_IMM: begin
        val = alu_calc(w.funct3, w.funct3 == F3_SR && imm[31:5] != 0, a, imm);
        wr  = 1'b1;
      end
      OP_REG: begin
        val = alu_calc(w.funct3, (w.funct3 == F3_ADD || w.funct3 == F3_SR) && w.funct7 != 0,
                       a, b);
        wr  = 1'b1;
      end
      OP_SYSTEM: begin
        if (w.funct3 != F3_ECALL) cause = CAUSE_ILLEGAL;
        else if (regs[REG_ECALL_ARG] == EXIT_CODE) cause = CAUSE_EXIT;
        else cause = CAUSE_ECALL;
      end
      default: cause = CAUSE_ILLEGAL;
    endcase
    if (cause != CAUSE_RUN) begin
      nxt = '0;
      wr  = 1'b0;
    end
    if (!wr || rd == 5'd0) begin
      rd  = '0;
      val = '0;
    end else begin
      regs[rd] = val;
    end
    r.next_pc     = nxt;
    r.write_index = rd;
    r.write_value = val;
    r.stop_cause  = cause;
    return r;
  endfunction

  function automatic in_word_t make_instr(logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
                                          logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                                          logic [31:0] imm, logic [31:0] pc);
    in_word_t w;
    w.opcode    = op;
    w.funct3    = f3;
    w.funct7    = f7;
    w.dest_reg  = rd;
    w.src_reg_a = ra;
    w.src_reg_b = rb;
    w.immediate = imm;
    w.pc_in     = pc;
    return w;
  endfunction

  function automatic logic [4:0] pick_reg();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 7);
    if (r == 6) return REG_ECALL_ARG;
    return $urandom_range(0, 31);
  endfunction

  function automatic logic [31:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return 32'h7fff_ffff;
      3:       return 32'h8000_0000;
      4, 5:    return $urandom_range(0, 64) - 32;
      default: return $urandom;
    endcase
  endfunction

  // keep most traffic on a few words around the wrap point, with aliased high bits
  function automatic logic [31:0] pick_data_addr();
    logic [31:0] addr;
    addr = (($urandom_range(0, 13) + MEM_WORDS - 2) % MEM_WORDS) * 4 + $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) addr += $urandom * (MEM_WORDS * 4);
    return addr;
  endfunction

  task automatic add_instr(in_word_t w, bit drain);
    program_item_t item;
    if (w.opcode == OP_STORE && w.funct3 <= F3_SW)
      last_store_addr = reg_value(w.src_reg_a) + w.immediate;
    item.instr   = w;
    item.outcome = execute_instr(w);
    item.drain   = drain;
    case ((n_queued / 50) % 3)
      0:       item.gap = 0;
      1:       item.gap = $urandom_range(0, 19);
      default: item.gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
    if (item.outcome.stop_cause != CAUSE_RUN) n_halts++;
    else if (w.opcode == OP_LOAD) n_loads++;
    else if (w.opcode == OP_STORE) n_stores++;
    program_q.push_back(item);
    n_queued++;
  endtask

  task automatic add_random_instr(bit drain);
    in_word_t    w;
    int unsigned kind;
    int          nb;
    bit          found;
    logic [31:0] target;
    kind = $urandom_range(0, 99);
    if (kind >= 92 && kind < 95 && $urandom_range(0, 1) == 1)
      add_instr(make_instr(OP_IMM, F3_ADD, $urandom, REG_ECALL_ARG, 5'd0, 5'd0, EXIT_CODE,
                           $urandom), 1'b0);
    w = in_word_t'({$urandom, $urandom, $urandom});
    w.dest_reg  = pick_reg();
    w.src_reg_a = pick_reg();
    w.src_reg_b = pick_reg();
    w.immediate = pick_imm();
    if (kind < 6) begin
      w.opcode = OP_LUI;
    end else if (kind < 10) begin
      w.opcode = OP_AUIPC;
    end else if (kind < 14) begin
      w.opcode = OP_JAL;
    end else if (kind < 18) begin
      w.opcode = OP_JALR;
      if ($urandom_range(0, 7) != 0) w.funct3 = F3_JALR;
    end else if (kind < 28) begin
      w.opcode = OP_BRANCH;
      if ($urandom_range(0, 3) == 0) w.src_reg_b = w.src_reg_a;
    end else if (kind < 42) begin
      w.opcode = OP_LOAD;
      case ($urandom_range(0, 6))
        0:       w.funct3 = F3_LB;
        1:       w.funct3 = F3_LH;
        2, 3:    w.funct3 = F3_LW;
        4:       w.funct3 = F3_LBU;
        5:       w.funct3 = F3_LHU;
        default: w.funct3 = ($urandom_range(0, 1) == 1) ? F3_LD_BAD : $urandom_range(6, 7);
      endcase
      nb = (w.funct3 == F3_LD_BAD || w.funct3 > F3_LHU) ? 1 : (1 << w.funct3[1:0]);
      found = 1'b0;
      for (int t = 0; t < 16 && !found; t++) begin
        target = pick_data_addr();
        found  = bytes_written(target, nb);
      end
      if (!found) begin
        target = last_store_addr;
        if (nb > 1) w.funct3 = ($urandom_range(0, 1) == 1) ? F3_LB : F3_LBU;
      end
      w.immediate = target - reg_value(w.src_reg_a);
    end else if (kind < 54) begin
      w.opcode = OP_STORE;
      if ($urandom_range(0, 6) != 0) w.funct3 = $urandom_range(F3_SB, F3_SW);
      else w.funct3 = $urandom_range(3, 7);
      target = ($urandom_range(0, 4) != 0) ? pick_data_addr() : $urandom;
      w.immediate = target - reg_value(w.src_reg_a);
    end else if (kind < 74) begin
      w.opcode = OP_IMM;
      if (w.funct3 == F3_SR && $urandom_range(0, 1) == 1)
        w.immediate = ($urandom_range(0, 1) == 1) ? {27'd0, w.immediate[4:0]}
                                                  : {21'd0, 6'h20, w.immediate[4:0]};
    end else if (kind < 92) begin
      w.opcode = OP_REG;
      case ($urandom_range(0, 3))
        0, 1:    w.funct7 = '0;
        2:       w.funct7 = F7_ALT;
        default: w.funct7 = $urandom;
      endcase
    end else if (kind < 95) begin
      w.opcode = OP_SYSTEM;
      if ($urandom_range(0, 4) != 0) w.funct3 = F3_ECALL;
    end
    add_instr(w, drain);
  endtask

  // driver: one word per item, gap drawn per item, optional drain before an item
  always @(posedge clk) begin
    if (rst) begin
      instr_valid <= 1'b0;
      instr       <= '0;
      drv_busy  = 1'b0;
      gap_armed = 1'b0;
      gap_left  = 0;
    end else begin
      if (drv_busy && !instr_stall) begin
        retire_q.push_back(drv_item.outcome);
        drv_busy = 1'b0;
      end
      if (!drv_busy && program_q.size() > 0) begin
        if (!gap_armed) begin
          gap_left  = program_q[0].gap;
          gap_armed = 1'b1;
        end
        if (!(program_q[0].drain && retire_q.size() > 0)) begin
          if (gap_left > 0) begin
            gap_left--;
          end else begin
            drv_item  = program_q.pop_front();
            drv_busy  = 1'b1;
            gap_armed = 1'b0;
          end
        end
      end
      instr_valid <= drv_busy;
      instr       <= drv_busy ? drv_item.instr : in_word_t'({$urandom, $urandom, $urandom});
    end
  end

  // monitor: compare each retired word with the oldest prediction, then draw a stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b1;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (retire_q.size() == 0) begin
          $error("unexpected result word %h", result);
          n_errors++;
        end else begin
          want = retire_q.pop_front();
          if (result.next_pc !== want.next_pc) begin
            $error("next_pc: expected %h, actual %h", want.next_pc, result.next_pc);
            n_errors++;
          end
          if (result.write_index !== want.write_index) begin
            $error("write_index: expected %0d, actual %0d", want.write_index,
                   result.write_index);
            n_errors++;
          end
          if (result.write_value !== want.write_value) begin
            $error("write_value: expected %h, actual %h", want.write_value,
                   result.write_value);
            n_errors++;
          end
          if (result.stop_cause !== want.stop_cause) begin
            $error("stop_cause: expected %0d, actual %0d", want.stop_cause,
                   result.stop_cause);
            n_errors++;
          end
          n_checked++;
        end
        case ((n_checked / 60) % 3)
          0:       stall_left = 0;
          1:       stall_left = $urandom_range(0, 19);
          default: stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
        endcase
      end
      result_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) regs[i] = '0;
    last_store_addr = '0;

    add_instr(make_instr(OP_LUI, $urandom, $urandom, 5'd1, 5'd0, 5'd0, 32'h8000_0000,
                         32'h0000_0004), 1'b0);
    add_instr(make_instr(OP_IMM, F3_ADD, 7'd0, 5'd2, 5'd0, 5'd0, 32'hffff_ffff,
                         32'h0000_0008), 1'b0);
    add_instr(make_instr(OP_IMM, F3_ADD, 7'd0, REG_ECALL_ARG, 5'd0, 5'd0, EXIT_CODE,
                         32'h0000_000c), 1'b0);
    add_instr(make_instr(OP_SYSTEM, F3_ECALL, 7'd0, 5'd3, 5'd0, 5'd0, $urandom,
                         32'h0000_0010), 1'b0);
    add_instr(make_instr(OP_IMM, F3_ADD, 7'd0, REG_ECALL_ARG, REG_ECALL_ARG, 5'd0, 32'd1,
                         32'h0000_0014), 1'b0);
    add_instr(make_instr(OP_SYSTEM, F3_ECALL, 7'h7f, 5'd0, 5'd0, 5'd0, 32'hffff_ffff,
                         32'h0000_0018), 1'b0);
    add_instr(make_instr(OP_STORE, F3_SW, 7'd0, 5'd0, 5'd0, 5'd2, 32'd0, 32'h0000_001c),
              1'b0);
    // halfword straddling the last word and word zero
    add_instr(make_instr(OP_STORE, F3_SH, 7'd0, 5'd0, 5'd0, 5'd1, MEM_WORDS * 4 - 1,
                         32'h0000_0020), 1'b0);
    add_instr(make_instr(OP_LOAD, F3_LW, 7'd0, 5'd3, 5'd0, 5'd0, MEM_WORDS * 4 - 1,
                         32'h0000_0024), 1'b0);
    add_instr(make_instr(OP_STORE, F3_SB, 7'd0, 5'd0, 5'd0, 5'd2, 32'd5, 32'h0000_0028),
              1'b0);
    add_instr(make_instr(OP_LOAD, F3_LB, 7'd0, 5'd4, 5'd0, 5'd0, 32'd5, 32'h0000_002c), 1'b0);
    add_instr(make_instr(OP_LOAD, F3_LBU, 7'd0, 5'd5, 5'd0, 5'd0, 32'd5, 32'h0000_0030),
              1'b0);
    add_instr(make_instr(OP_LOAD, F3_LH, 7'd0, 5'd6, 5'd1, 5'd0, 32'h8000_0000,
                         32'h0000_0034), 1'b0);
    add_instr(make_instr(OP_REG, F3_ADD, 7'd0, 5'd8, 5'd1, 5'd2, 32'd0, 32'h0000_0038), 1'b0);
    add_instr(make_instr(OP_REG, F3_ADD, F7_ALT, 5'd9, 5'd1, 5'd2, 32'd0, 32'h0000_003c),
              1'b0);
    add_instr(make_instr(OP_IMM, F3_SR, 7'd0, 5'd10, 5'd1, 5'd0, 32'h0000_041f,
                         32'h0000_0040), 1'b0);
    add_instr(make_instr(OP_REG, F3_SLT, 7'd0, 5'd13, 5'd1, 5'd2, 32'd0, 32'h0000_0044),
              1'b0);
    add_instr(make_instr(OP_JAL, $urandom, $urandom, 5'd15, 5'd0, 5'd0, 32'hffff_fff8,
                         32'h0000_0004), 1'b0);
    add_instr(make_instr(OP_JALR, F3_JALR, 7'd0, 5'd16, 5'd2, 5'd0, 32'd0, 32'hffff_fffc),
              1'b0);
    add_instr(make_instr(OP_BRANCH, F3_BEQ, 7'd0, 5'd0, 5'd0, 5'd0, 32'h7fff_fffe,
                         32'h0000_0050), 1'b0);
    add_instr(make_instr(OP_BRANCH, F3_BR_BAD, 7'd0, 5'd7, 5'd0, 5'd0, 32'd16,
                         32'h0000_0054), 1'b0);
    add_instr(make_instr(OP_LOAD, F3_LD_BAD, 7'd0, 5'd7, 5'd0, 5'd0, 32'd0, 32'h0000_0058),
              1'b0);
    add_instr(make_instr(OP_UNKNOWN, 3'd7, 7'h7f, 5'd31, 5'd31, 5'd31, 32'hffff_ffff,
                         32'hffff_ffff), 1'b0);
    add_instr(make_instr(OP_IMM, F3_ADD, 7'd0, 5'd0, 5'd0, 5'd0, 32'd5, 32'h0000_0060), 1'b0);
    add_instr(make_instr(OP_AUIPC, $urandom, $urandom, 5'd18, 5'd0, 5'd0, 32'hffff_f000,
                         32'h0000_0000), 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) add_random_instr(i == 180 || i == 400);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    cycles = 0;
    while ((program_q.size() > 0 || drv_busy || retire_q.size() > 0) && cycles < CYCLE_LIMIT)
    begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      $display("executed %0d instructions (%0d loads, %0d stores, %0d halts) in %0d cycles",
               n_queued, n_loads, n_stores, n_halts, cycles);
      $display("checked %0d result words, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire
